[sv/crhp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crhp_pkg
// types and character constants shared by the content-range header parser
// ----------------------------------------------------------------------------
package crhp_pkg;

  localparam int RESULT_BITS = 32;

  // characters seen by the parser
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // length of the "bytes" unit keyword
  localparam logic [2:0] KW_LEN = 3'd5;

  typedef enum logic [3:0] {
    PH_LEAD = 4'd0,
    PH_KEY  = 4'd1,
    PH_GAP  = 4'd2,
    PH_NUM1 = 4'd3,
    PH_SEP2 = 4'd4,
    PH_NUM2 = 4'd5,
    PH_SEP3 = 4'd6,
    PH_NUM3 = 4'd7,
    PH_DONE = 4'd8,
    PH_FAIL = 4'd9
  } phase_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       is_final;
  } hdr_item_t;

  typedef struct packed {
    logic                   range_valid;
    logic [RESULT_BITS-1:0] range_first;
    logic [RESULT_BITS-1:0] range_last;
    logic [RESULT_BITS-1:0] range_total;
  } res_item_t;

  // character of the unit keyword at a given position
  function automatic logic [7:0] keyword_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h62; // b
      3'd1:    ch = 8'h79; // y
      3'd2:    ch = 8'h74; // t
      3'd3:    ch = 8'h65; // e
      3'd4:    ch = 8'h73; // s
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[sv/crhp_digit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crhp_digit
// saturating decimal accumulate: acc * 10 + digit, clamped to all ones
// ----------------------------------------------------------------------------
module crhp_digit #(
  parameter int VALUE_BITS = 32
) (
  input  logic [VALUE_BITS-1:0] acc,
  input  logic [3:0]            digit,
  output logic [VALUE_BITS-1:0] sum
);

  logic [VALUE_BITS+3:0] acc_wide;
  logic [VALUE_BITS+3:0] sum_wide;

  // times ten as two shifts, no multiplier needed
  assign acc_wide = {4'b0000, acc};
  assign sum_wide = (acc_wide << 3) + (acc_wide << 1) + {{VALUE_BITS{1'b0}}, digit};

  assign sum = (sum_wide[VALUE_BITS+3:VALUE_BITS] != 4'b0000)
               ? {VALUE_BITS{1'b1}} : sum_wide[VALUE_BITS-1:0];

endmodule

[sv/crhp_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crhp_parser
// phase machine and number accumulators, one header byte per step
// ----------------------------------------------------------------------------
module crhp_parser import crhp_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  hdr_item_t hdr,
  output res_item_t result
);

  phase_t                phase;
  phase_t                phase_next;
  logic [2:0]            keyword_pos;
  logic [2:0]            keyword_pos_next;
  logic [VALUE_BITS-1:0] first_acc;
  logic [VALUE_BITS-1:0] first_acc_next;
  logic [VALUE_BITS-1:0] second_acc;
  logic [VALUE_BITS-1:0] second_acc_next;
  logic [VALUE_BITS-1:0] third_acc;
  logic [VALUE_BITS-1:0] third_acc_next;

  logic [7:0]             ch;
  logic                   is_digit;
  logic                   kw_match;
  logic [VALUE_BITS-1:0]  digit_acc;
  logic [VALUE_BITS-1:0]  digit_sum;
  logic                   ok;
  logic [RESULT_BITS-1:0] first_w;
  logic [RESULT_BITS-1:0] last_w;
  logic [RESULT_BITS-1:0] total_w;

  assign ch       = hdr.header_byte;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign kw_match = (keyword_pos < KW_LEN) && (ch == keyword_char(keyword_pos));

  // only one number grows per byte, so one digit unit serves all three
  always_comb begin
    unique case (phase)
      PH_NUM1: digit_acc = first_acc;
      PH_NUM2: digit_acc = second_acc;
      PH_NUM3: digit_acc = third_acc;
      default: digit_acc = '0;
    endcase
  end

  crhp_digit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_digit (
    .acc  (digit_acc),
    .digit(ch[3:0]),
    .sum  (digit_sum)
  );

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_LEAD: begin
        if (ch == CH_SPACE) begin
          phase_next = PH_LEAD;
        end else if (ch == keyword_char(3'd0)) begin
          phase_next = PH_KEY;
        end else if (is_digit) begin
          phase_next = PH_NUM1;
        end else begin
          phase_next = PH_FAIL;
        end
      end
      PH_KEY: begin
        if (!kw_match) begin
          phase_next = PH_FAIL;
        end else if (keyword_pos == KW_LEN - 3'd1) begin
          phase_next = PH_GAP;
        end
      end
      PH_GAP: begin
        if (ch == CH_SPACE) begin
          phase_next = PH_GAP;
        end else if (is_digit) begin
          phase_next = PH_NUM1;
        end else begin
          phase_next = PH_FAIL;
        end
      end
      PH_NUM1: begin
        if (!is_digit) begin
          phase_next = (ch == CH_DASH) ? PH_SEP2 : PH_FAIL;
        end
      end
      PH_SEP2: phase_next = is_digit ? PH_NUM2 : PH_FAIL;
      PH_NUM2: begin
        if (!is_digit) begin
          phase_next = (ch == CH_SLASH) ? PH_SEP3 : PH_FAIL;
        end
      end
      PH_SEP3: phase_next = is_digit ? PH_NUM3 : PH_FAIL;
      PH_NUM3: begin
        if (!is_digit) begin
          phase_next = PH_DONE;
        end
      end
      PH_DONE: phase_next = PH_DONE;
      default: phase_next = PH_FAIL;
    endcase
  end

  // keyword position and accumulators
  always_comb begin
    keyword_pos_next = keyword_pos;
    first_acc_next   = first_acc;
    second_acc_next  = second_acc;
    third_acc_next   = third_acc;
    if (phase == PH_LEAD && ch == keyword_char(3'd0)) begin
      keyword_pos_next = 3'd1;
    end else if (phase == PH_KEY && kw_match) begin
      keyword_pos_next = keyword_pos + 3'd1;
    end
    if (is_digit) begin
      if (phase == PH_LEAD || phase == PH_GAP || phase == PH_NUM1) begin
        first_acc_next = digit_sum;
      end
      if (phase == PH_SEP2 || phase == PH_NUM2) begin
        second_acc_next = digit_sum;
      end
      if (phase == PH_SEP3 || phase == PH_NUM3) begin
        third_acc_next = digit_sum;
      end
    end
  end

  // result as seen after this byte
  assign ok = (phase_next == PH_NUM3 || phase_next == PH_DONE)
              && (first_acc_next <= second_acc_next)
              && (second_acc_next < third_acc_next);

  if (VALUE_BITS >= RESULT_BITS) begin : g_trunc
    assign first_w = first_acc_next[RESULT_BITS-1:0];
    assign last_w  = second_acc_next[RESULT_BITS-1:0];
    assign total_w = third_acc_next[RESULT_BITS-1:0];
  end else begin : g_ext
    assign first_w = {{(RESULT_BITS-VALUE_BITS){1'b0}}, first_acc_next};
    assign last_w  = {{(RESULT_BITS-VALUE_BITS){1'b0}}, second_acc_next};
    assign total_w = {{(RESULT_BITS-VALUE_BITS){1'b0}}, third_acc_next};
  end

  always_comb begin
    result.range_valid = ok;
    result.range_first = ok ? first_w : '0;
    result.range_last  = ok ? last_w  : '0;
    result.range_total = ok ? total_w : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEAD;
      keyword_pos <= '0;
      first_acc   <= '0;
      second_acc  <= '0;
      third_acc   <= '0;
    end else if (step) begin
      if (hdr.is_final) begin
        // rearm for the next header
        phase       <= PH_LEAD;
        keyword_pos <= '0;
        first_acc   <= '0;
        second_acc  <= '0;
        third_acc   <= '0;
      end else begin
        phase       <= phase_next;
        keyword_pos <= keyword_pos_next;
        first_acc   <= first_acc_next;
        second_acc  <= second_acc_next;
        third_acc   <= third_acc_next;
      end
    end
  end

endmodule

[sv/content_range_header_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// content_range_header_parser
// byte-serial parser for "bytes first-last/total" range headers
// ----------------------------------------------------------------------------
// Header bytes enter one item per clock on the hdr channel; is_final marks the
// last byte of a header, and only that item produces a result on the res
// channel. The block sustains one item per cycle while no final byte waits on
// an unclaimed result: each byte is captured in an input register, then one
// pass of phase logic and a single saturating times-ten-plus-digit unit
// updates the parser state. A result is registered in the output register as
// its final byte leaves the input register. Non-final bytes never wait on the
// output side; a final byte waits in the input register only while an earlier
// result is still unclaimed. Numbers saturate at all ones of VALUE_BITS and
// are reported in 32 bits; when range_valid is low the three value fields
// read as zero. After each final byte the parser rearms to its reset state.
// ----------------------------------------------------------------------------
module content_range_header_parser import crhp_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      hdr_valid,
  output logic      hdr_ready,
  input  hdr_item_t hdr_data,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res_data
);

  // input register
  hdr_item_t hdr_q;
  logic      hdr_q_valid;

  // parse step
  logic      fire;
  res_item_t result;

  // a final byte needs a free result slot, any other byte goes straight in
  assign fire = hdr_q_valid && (!hdr_q.is_final || !res_valid || res_ready);

  // the input register refills in the same cycle that it drains
  assign hdr_ready = !hdr_q_valid || fire;

  crhp_parser #(
    .VALUE_BITS(VALUE_BITS)
  ) u_parser (
    .clk   (clk),
    .rst   (rst),
    .step  (fire),
    .hdr   (hdr_q),
    .result(result)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_q_valid <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (hdr_ready) begin
        hdr_q_valid <= hdr_valid;
      end
      if (fire && hdr_q.is_final) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (hdr_valid && hdr_ready) begin
      hdr_q <= hdr_data;
    end
    if (fire && hdr_q.is_final) begin
      res_data <= result;
    end
  end

endmodule

[sv/crhp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crhp_checker
// port-level checks on the range header parser, bound to the top level
// ----------------------------------------------------------------------------
module crhp_checker import crhp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      hdr_valid,
  input logic      hdr_ready,
  input hdr_item_t hdr_data,
  input logic      res_valid,
  input logic      res_ready,
  input res_item_t res_data
);

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered after reset");

  // a header item waiting at the input holds
  a_hdr_hold: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && !hdr_ready |=> hdr_valid && $stable(hdr_data))
    else $error("stalled header item changed");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  // a rejected header reports zero values
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.range_valid |->
      res_data.range_first == '0 && res_data.range_last == '0
      && res_data.range_total == '0)
    else $error("invalid result carries values");

  // an accepted range is ordered
  a_valid_order: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.range_valid |->
      res_data.range_first <= res_data.range_last
      && res_data.range_last < res_data.range_total)
    else $error("valid result out of order");

endmodule

bind content_range_header_parser crhp_checker u_crhp_checker (
  .clk      (clk),
  .rst      (rst),
  .hdr_valid(hdr_valid),
  .hdr_ready(hdr_ready),
  .hdr_data (hdr_data),
  .res_valid(res_valid),
  .res_ready(res_ready),
  .res_data (res_data)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the content-range header parser: header text is
// fed one byte per item, an independent parser model predicts each range
// result on the final byte, and every result is checked field by field
// ----------------------------------------------------------------------------
module testbench;
  import crhp_pkg::*;

  // stimulus size and pacing
  localparam int STREAM_ITEMS = 1550;
  localparam int QUIET_TAIL   = 200;   // last items go through with no idling
  localparam int HOLD_AFTER   = 30;    // results seen before the long hold-off
  localparam int LONG_HOLD    = 300;   // receiver hold-off, in cycles
  localparam int STALL_LIMIT  = 2000;  // cycles with no item moving
  localparam int DRAIN_CYCLES = 8;     // settling time after the last result

  // the optional unit keyword, first character in the top byte
  localparam logic [39:0] UNIT_WORD = "bytes";
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      hdr_valid = 1'b0;
  logic      hdr_ready;
  hdr_item_t hdr_data  = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  res_item_t res_data;

  // header bytes waiting to be sent, and the header being assembled
  hdr_item_t  header_stream[$];
  logic [7:0] draft[$];

  // ranges predicted but not yet seen on the output
  res_item_t pending_ranges[$];

  // parser model state
  phase_t      hp_phase;
  logic [2:0]  kw_count;
  logic [31:0] num_first;
  logic [31:0] num_last;
  logic [31:0] num_total;

  // handshakes seen at the last rising edge
  bit hdr_took;
  bit res_took;

  int fail_count  = 0;
  int ranges_seen = 0;
  int send_gap    = 0;
  int stall_left  = 0;
  int idle_cycles = 0;
  bit hold_done   = 1'b0;

  content_range_header_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .hdr_valid (hdr_valid),
    .hdr_ready (hdr_ready),
    .hdr_data  (hdr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] unit_char(input int pos);
    return UNIT_WORD[8*(4-pos) +: 8];
  endfunction

  function automatic bit is_digit(input logic [7:0] ch);
    return ch >= CH_ZERO && ch <= CH_NINE;
  endfunction

  // times ten plus digit, pinned at all ones once it no longer fits
  function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [7:0] ch);
    logic [35:0] wide;
    wide = acc * 36'd10 + (ch - CH_ZERO);
    return (wide > {4'd0, ALL_ONES}) ? ALL_ONES : wide[31:0];
  endfunction

  function automatic void clear_parser();
    hp_phase  = PH_LEAD;
    kw_count  = 3'd0;
    num_first = '0;
    num_last  = '0;
    num_total = '0;
  endfunction

  // advance the model by one byte; a final byte also yields the expected range
  function automatic void parse_header_byte(input hdr_item_t item);
    logic [7:0] ch;
    bit         ok;
    res_item_t  want;
    ch = item.header_byte;
    case (hp_phase)
      PH_LEAD: begin
        if (ch == CH_SPACE) begin
          // still skipping leading spaces
        end else if (ch == unit_char(0)) begin
          kw_count = 3'd1;
          hp_phase = PH_KEY;
        end else if (is_digit(ch)) begin
          num_first = add_digit('0, ch);
          hp_phase  = PH_NUM1;
        end else begin
          hp_phase = PH_FAIL;
        end
      end
      PH_KEY: begin
        if (kw_count < KW_LEN && ch == unit_char(kw_count)) begin
          kw_count = kw_count + 3'd1;
          if (kw_count == KW_LEN) hp_phase = PH_GAP;
        end else begin
          hp_phase = PH_FAIL;
        end
      end
      PH_GAP: begin
        if (ch == CH_SPACE) begin
          // spaces after the keyword
        end else if (is_digit(ch)) begin
          num_first = add_digit('0, ch);
          hp_phase  = PH_NUM1;
        end else begin
          hp_phase = PH_FAIL;
        end
      end
      PH_NUM1: begin
        if (is_digit(ch)) num_first = add_digit(num_first, ch);
        else hp_phase = (ch == CH_DASH) ? PH_SEP2 : PH_FAIL;
      end
      PH_SEP2: begin
        if (is_digit(ch)) begin
          num_last = add_digit('0, ch);
          hp_phase = PH_NUM2;
        end else begin
          hp_phase = PH_FAIL;
        end
      end
      PH_NUM2: begin
        if (is_digit(ch)) num_last = add_digit(num_last, ch);
        else hp_phase = (ch == CH_SLASH) ? PH_SEP3 : PH_FAIL;
      end
      PH_SEP3: begin
        if (is_digit(ch)) begin
          num_total = add_digit('0, ch);
          hp_phase  = PH_NUM3;
        end else begin
          hp_phase = PH_FAIL;
        end
      end
      PH_NUM3: begin
        // anything but a digit closes the third number, zero byte included
        if (is_digit(ch)) num_total = add_digit(num_total, ch);
        else hp_phase = PH_DONE;
      end
      PH_DONE: begin
        // trailing text is ignored
      end
      default: begin
        hp_phase = PH_FAIL;
      end
    endcase
    if (item.is_final) begin
      ok = (hp_phase == PH_NUM3 || hp_phase == PH_DONE) &&
           num_first <= num_last && num_last < num_total;
      want.range_valid = ok;
      want.range_first = ok ? num_first : '0;
      want.range_last  = ok ? num_last  : '0;
      want.range_total = ok ? num_total : '0;
      pending_ranges.push_back(want);
      clear_parser();
    end
  endfunction

  // compare one result against the oldest predicted range
  function automatic void check_range(input res_item_t got);
    res_item_t want;
    if (pending_ranges.size() == 0) begin
      $error("range result with none expected: valid %0d first %0d last %0d total %0d",
             got.range_valid, got.range_first, got.range_last, got.range_total);
      fail_count++;
    end else begin
      want = pending_ranges.pop_front();
      if (got.range_valid !== want.range_valid) begin
        $error("range_valid: expected %0d, got %0d", want.range_valid, got.range_valid);
        fail_count++;
      end
      if (got.range_first !== want.range_first) begin
        $error("range_first: expected %0d, got %0d", want.range_first, got.range_first);
        fail_count++;
      end
      if (got.range_last !== want.range_last) begin
        $error("range_last: expected %0d, got %0d", want.range_last, got.range_last);
        fail_count++;
      end
      if (got.range_total !== want.range_total) begin
        $error("range_total: expected %0d, got %0d", want.range_total, got.range_total);
        fail_count++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // header text generation
  // ---------------------------------------------------------------------------

  // '#' in a directed header stands for a zero byte
  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) draft.push_back((s[i] == "#") ? 8'h00 : s[i]);
  endfunction

  function automatic void put_number(input longint unsigned v);
    if ($urandom_range(0, 7) == 0) put_text("0");
    put_text($sformatf("%0d", v));
  endfunction

  // move the draft into the send queue, final flag on its last byte
  function automatic void ship_draft();
    hdr_item_t item;
    for (int i = 0; i < draft.size(); i++) begin
      item.header_byte = draft[i];
      item.is_final    = (i == draft.size() - 1);
      header_stream.push_back(item);
    end
    draft.delete();
  endfunction

  // mostly small numbers, some near the 32-bit edge, some far past it
  function automatic longint unsigned pick_value();
    longint unsigned v;
    case ($urandom_range(0, 4))
      0: v = 64'($urandom_range(0, 20));
      1: v = 64'($urandom_range(0, 99999));
      2: v = 64'($urandom);
      3: v = 64'hFFFF_FFFF - $urandom_range(0, 3);
      default: v = {$urandom, $urandom} >> $urandom_range(24, 40);
    endcase
    return v;
  endfunction

  // a well-formed header with random content, usually an ordered range
  function automatic void draft_range_header();
    longint unsigned a;
    longint unsigned b;
    longint unsigned c;
    a = pick_value();
    if ($urandom_range(0, 3) != 0) begin
      b = a + (($urandom_range(0, 3) == 0) ? 0 : pick_value());
      c = b + 1 + (($urandom_range(0, 3) == 0) ? 0 : pick_value());
    end else begin
      b = pick_value();
      c = pick_value();
    end
    repeat ($urandom_range(0, 2)) put_text(" ");
    if ($urandom_range(0, 3) != 0) begin
      put_text("bytes");
      repeat ($urandom_range(0, 2)) put_text(" ");
    end
    put_number(a);
    put_text("-");
    put_number(b);
    put_text("/");
    put_number(c);
    case ($urandom_range(0, 4))
      1: put_text(" ");
      2: draft.push_back(8'($urandom_range(0, 255)));
      3: begin
        draft.push_back(8'h00);
        repeat ($urandom_range(1, 3)) draft.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endfunction

  function automatic void draft_random_header();
    int pos;
    int n;
    case ($urandom_range(0, 9))
      7: begin
        // well-formed text with one byte hit or dropped
        draft_range_header();
        pos = $urandom_range(0, draft.size() - 1);
        if ($urandom_range(0, 1) == 1 && draft.size() > 1) draft.delete(pos);
        else draft[pos] = 8'($urandom_range(0, 255));
      end
      8: begin
        // keyword cut short by a random byte
        repeat ($urandom_range(0, 2)) put_text(" ");
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) draft.push_back(unit_char(i));
        draft.push_back(8'($urandom_range(0, 255)));
        put_text(" 1-2/3");
      end
      9: begin
        // raw noise
        repeat ($urandom_range(1, 8)) draft.push_back(8'($urandom_range(0, 255)));
      end
      default: draft_range_header();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // prediction, checking and watchdog at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    hdr_took = !rst && hdr_valid && hdr_ready;
    res_took = !rst && res_valid && res_ready;
    if (rst) begin
      clear_parser();
    end else begin
      if (hdr_took) parse_header_byte(hdr_data);
      if (res_took) begin
        check_range(res_data);
        ranges_seen++;
      end
    end
  end

  // ends the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (hdr_valid && hdr_ready) || (res_valid && res_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers at the falling edge
  // ---------------------------------------------------------------------------

  // header sender: next item once the current one is taken, random gaps
  always @(negedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
    end else if (!hdr_valid || hdr_took) begin
      if (send_gap > 0) begin
        hdr_valid <= 1'b0;
        send_gap--;
      end else if (header_stream.size() > 0) begin
        hdr_valid <= 1'b1;
        hdr_data  <= header_stream.pop_front();
        if (header_stream.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
          send_gap = $urandom_range(1, 15);
      end else begin
        hdr_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, plus one long hold-off that backs the
  // parser up until a final byte is stuck at its input
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (stall_left > 0) begin
      res_ready <= 1'b0;
      stall_left--;
    end else begin
      res_ready <= 1'b1;
      if (!hold_done && ranges_seen >= HOLD_AFTER) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
      end else if (header_stream.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    string directed_headers[$];
    directed_headers = '{
      "bytes 0-0/1",                         // smallest valid range
      "0-4294967294/4294967295",             // no keyword, 32-bit extremes
      "bytes 0-4294967294/99999999999",      // total saturates, still valid
      "  bytes  18446744073709551616-1/2",   // first saturates past last
      "bytes 5-4/10",                        // first above last
      "bytes 1-9/9",                         // last equal to total
      "byte 1-2/3",                          // keyword broken by a space
      "bb",                                  // keyword broken early
      "bytes1-2/3",                          // no gap after keyword
      "bytes 1 -2/3",                        // space inside the range
      "bytes -2/3",                          // first number missing
      "bytes 1-/3",                          // second number missing
      "bytes 1-2/",                          // third number missing
      "bytes 1-2/3xyz",                      // trailing text ignored
      "bytes 1-2/3#junk",                    // zero byte closes the text
      "bytes 1-2#/3",                        // zero byte before the slash
      "#bytes 0-1/2",                        // zero byte first
      "7",                                   // lone digit
      "x",                                   // lone junk byte
      "bytes 00012-00013/014 ",              // leading zeros, space last
      "   0042-0042/43"                      // spaces, no keyword
    };
    foreach (directed_headers[i]) begin
      put_text(directed_headers[i]);
      ship_draft();
    end
    while (header_stream.size() < STREAM_ITEMS) begin
      draft_random_header();
      ship_draft();
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // everything sent, taken and answered
    while (header_stream.size() != 0 || hdr_valid || pending_ranges.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[content_range_header_parser.f]
sv/crhp_pkg.sv
sv/crhp_digit.sv
sv/crhp_parser.sv
sv/content_range_header_parser.sv
sv/crhp_checker.sv
test/testbench.sv
